// ===== design/swf_pkg.sv =====
package swf_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BIT_PERIOD  = 1'b0,
    CFG_GAP_PERIODS = 1'b1
  } swf_cfg_e;

  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned GapW       = 4;
  localparam int unsigned TickW      = 12;
  localparam int unsigned BitIdxW    = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;

  // Register reset values.
  localparam logic [PeriodW-1:0] BitPeriodRst  = 8'd16;
  localparam logic [GapW-1:0]    GapPeriodsRst = 4'd4;

  // Bit positions within a frame.
  localparam logic [BitIdxW-1:0] ShortCutBit = 4'd3;
  localparam logic [BitIdxW-1:0] StopBit     = 4'd10;
  localparam logic [BitIdxW-1:0] MoreBit     = 4'd11;
  localparam logic [BitIdxW-1:0] GuardBit    = 4'd12;

  // Stream widths.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // Result of one word, handed from the engine to the output stage.
  typedef struct packed {
    logic tx_line;
    logic busy_res;
    logic start_accepted;
  } swf_result_t;

endpackage

// ===== design/swf_engine.sv =====
module swf_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          command_i,
  input  logic [swf_pkg::WordW-1:0]     send_word_i,
  input  logic                          rx_active_i,
  input  logic                          cfg_we_i,
  input  logic [swf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [swf_pkg::CfgDataW-1:0]  cfg_data_i,
  output swf_pkg::swf_result_t          result_o
);
  import swf_pkg::*;

  logic [PeriodW-1:0] bit_period_q;
  logic [GapW-1:0]    gap_periods_q;

  logic               sending_q, sending_d;
  logic [BitIdxW-1:0] bit_index_q, bit_index_d;
  logic [ByteW-1:0]   shift_byte_q, shift_byte_d;
  logic [ByteW-1:0]   low_byte_hold_q, low_byte_hold_d;
  logic               short_request_q, short_request_d;
  logic               more_flag_q, more_flag_d;
  logic               next_level_q, next_level_d;
  logic               line_level_q, line_level_d;
  logic [TickW-1:0]   tick_count_q, tick_count_d;

  logic               start_ok;
  logic [BitIdxW-1:0] bit_index_inc;
  logic [TickW-1:0]   gap_reload;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= BitPeriodRst;
      gap_periods_q <= GapPeriodsRst;
    end else if (cfg_we_i) begin
      case (swf_cfg_e'(cfg_index_i))
        CFG_BIT_PERIOD:  bit_period_q  <= cfg_data_i[PeriodW-1:0];
        CFG_GAP_PERIODS: gap_periods_q <= cfg_data_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  assign start_ok      = command_i && !sending_q && !rx_active_i;
  assign bit_index_inc = bit_index_q + BitIdxW'(1);
  assign gap_reload    = TickW'(gap_periods_q) * TickW'(bit_period_q);

  // Next state for one accepted word: a start request or one timer tick.
  always_comb begin
    sending_d       = sending_q;
    bit_index_d     = bit_index_q;
    shift_byte_d    = shift_byte_q;
    low_byte_hold_d = low_byte_hold_q;
    short_request_d = short_request_q;
    more_flag_d     = more_flag_q;
    next_level_d    = next_level_q;
    line_level_d    = line_level_q;
    tick_count_d    = tick_count_q;

    if (command_i) begin
      if (start_ok) begin
        sending_d       = 1'b1;
        bit_index_d     = '0;
        next_level_d    = 1'b1;
        more_flag_d     = 1'b1;
        shift_byte_d    = send_word_i[WordW-1:ByteW];
        low_byte_hold_d = send_word_i[ByteW-1:0];
        short_request_d = send_word_i[WordW-1];
        tick_count_d    = TickW'(bit_period_q);
      end
    end else if (sending_q) begin
      if (tick_count_q <= TickW'(1)) begin
        // Bit edge: show the prepared level and prepare the following one.
        line_level_d = next_level_q;
        bit_index_d  = bit_index_inc;
        tick_count_d = TickW'(bit_period_q);
        if (bit_index_inc == ShortCutBit && short_request_q) begin
          bit_index_d  = MoreBit;
          next_level_d = 1'b0;
          more_flag_d  = 1'b0;
        end else if (bit_index_inc < StopBit) begin
          next_level_d = shift_byte_q[ByteW-1];
          shift_byte_d = {shift_byte_q[ByteW-2:0], 1'b0};
        end else if (bit_index_inc == StopBit) begin
          next_level_d = more_flag_q;
        end else if (bit_index_inc == MoreBit) begin
          next_level_d = 1'b0;
        end else begin
          // Guard bit: either the frame ends or the low byte follows a gap.
          next_level_d = more_flag_q;
          bit_index_d  = '0;
          if (!more_flag_q) begin
            sending_d = 1'b0;
          end else begin
            more_flag_d  = 1'b0;
            shift_byte_d = low_byte_hold_q;
            tick_count_d = gap_reload;
          end
        end
      end else begin
        tick_count_d = tick_count_q - TickW'(1);
      end
    end
  end

  // Transmitter state advances once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q       <= 1'b0;
      bit_index_q     <= '0;
      shift_byte_q    <= '0;
      low_byte_hold_q <= '0;
      short_request_q <= 1'b0;
      more_flag_q     <= 1'b0;
      next_level_q    <= 1'b0;
      line_level_q    <= 1'b0;
      tick_count_q    <= '0;
    end else if (accept_i) begin
      sending_q       <= sending_d;
      bit_index_q     <= bit_index_d;
      shift_byte_q    <= shift_byte_d;
      low_byte_hold_q <= low_byte_hold_d;
      short_request_q <= short_request_d;
      more_flag_q     <= more_flag_d;
      next_level_q    <= next_level_d;
      line_level_q    <= line_level_d;
      tick_count_q    <= tick_count_d;
    end
  end

  // The result reflects the state after this word.
  assign result_o.tx_line        = line_level_d;
  assign result_o.busy_res       = sending_d;
  assign result_o.start_accepted = start_ok;

  // The bit counter never passes the guard bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bit_index_q <= GuardBit)
    else $error("bit counter past guard bit");

  // A short request frame skips the data bits from the short cut to the stop bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sending_q && short_request_q) |-> (bit_index_q < ShortCutBit || bit_index_q >= MoreBit))
    else $error("short request frame entered the data bits");

  // An accepted start leaves the transmitter busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && start_ok) |=> sending_q)
    else $error("accepted start did not set busy");

endmodule

// ===== design/swf_out_stage.sv =====
module swf_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  swf_pkg::swf_result_t           result_i,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [swf_pkg::OutDataW-1:0]   m_axis_tdata
);
  import swf_pkg::*;

  logic                valid_q;
  logic [OutDataW-1:0] data_q;

  // A new word may enter whenever the held one is gone or leaves now.
  assign in_ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Result fields packed from the lowest bit up.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= {(OutDataW-3)'(0), result_i.start_accepted, result_i.busy_res,
                 result_i.tx_line};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

// ===== design/serial_word_framer_tx_core.sv =====
// Serial word framer, transmit side. Each input word is either one timer tick
// (tuser 0) or a request to start sending send_word (tuser 1); every input word
// gives exactly one output word with the line level, the busy flag and whether
// a start was taken. One word is accepted every clock cycle while the output
// side keeps up; each result is registered as its word is accepted, held in
// a single output register. Input stalls only while that register holds a
// result and the output is not ready, and resumes in the cycle the result
// leaves. Line timing is counted in ticks: bit_period ticks per bit and
// gap_periods bit periods between bytes.
module serial_word_framer_tx_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [swf_pkg::InDataW-1:0]    s_axis_tdata,  // [15:0] send_word, [16] rx_active
  input  logic                           s_axis_tuser,  // [0] command
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [swf_pkg::OutDataW-1:0]   m_axis_tdata,  // [0] tx_line, [1] busy_res,
                                                        // [2] start_accepted
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [swf_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [swf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import swf_pkg::*;

  logic        accept;
  swf_result_t result;

  assign accept = s_axis_tvalid && s_axis_tready;

  swf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (s_axis_tuser),
    .send_word_i (s_axis_tdata[WordW-1:0]),
    .rx_active_i (s_axis_tdata[WordW]),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result)
  );

  swf_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .result_i      (result),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
